// ----- design/sbsfa_pkg.sv -----
// ----------------------------------------------------------------------------
// sbsfa_pkg
// Shared types and constants for the sprite bounce, scale and fade animator.
// ----------------------------------------------------------------------------
package sbsfa_pkg;

  localparam int COORD_W = 12;
  localparam int TIME_W  = 32;
  localparam int PER_W   = 16;
  localparam int STEP_W  = 8;
  localparam int ALPHA_W = 8;
  localparam int QUO_W   = COORD_W;
  localparam int PROD_W  = COORD_W + PER_W;
  localparam int CNT_W   = $clog2(QUO_W);
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 72;

  localparam logic [COORD_W-1:0] WIN_W_RST = COORD_W'(800);
  localparam logic [COORD_W-1:0] WIN_H_RST = COORD_W'(480);
  localparam logic [COORD_W-1:0] MIN_RST   = COORD_W'(64);
  localparam logic [COORD_W-1:0] MAX_RST   = COORD_W'(400);
  localparam logic [PER_W-1:0]   PER_RST   = PER_W'(1000);
  localparam logic [ALPHA_W-1:0] FULL_ALPHA = ALPHA_W'(255);

  // Register indexes on the configuration port.
  localparam logic [IDX_W-1:0] CFG_WIN_W     = 3'd0;
  localparam logic [IDX_W-1:0] CFG_WIN_H     = 3'd1;
  localparam logic [IDX_W-1:0] CFG_MIN_W     = 3'd2;
  localparam logic [IDX_W-1:0] CFG_MIN_H     = 3'd3;
  localparam logic [IDX_W-1:0] CFG_MAX_W     = 3'd4;
  localparam logic [IDX_W-1:0] CFG_MAX_H     = 3'd5;
  localparam logic [IDX_W-1:0] CFG_FADE_PER  = 3'd6;
  localparam logic [IDX_W-1:0] CFG_SCALE_PER = 3'd7;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_DIV,
    ST_WB,
    ST_MOVE,
    ST_FADE,
    ST_DONE
  } ctrl_state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_START,
    DP_SCALE_CHK,
    DP_MUL,
    DP_DIV_STEP,
    DP_WRITE,
    DP_MOVE,
    DP_FADE_CHK,
    DP_PUBLISH
  } dp_op_t;

  typedef enum logic [1:0] {
    RAMP_W,
    RAMP_H,
    RAMP_A
  } ramp_sel_t;

  typedef struct packed {
    dp_op_t    op;
    ramp_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic is_start;
    logic scale_due;
    logic fade_due;
    logic out_free;
  } dp_status_t;

endpackage

// ----- design/sbsfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// sbsfa_ctrl
// Sequencer: loads the sprite for a start word and steps the datapath through size, motion and alpha for a tick.
// ----------------------------------------------------------------------------
module sbsfa_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  sbsfa_pkg::dp_status_t status,
  output sbsfa_pkg::dp_cmd_t    cmd
);
  import sbsfa_pkg::*;

  ctrl_state_t      state_r, state_nxt;
  ramp_sel_t        sel_r, sel_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= RAMP_W;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cnt_nxt   = cnt_r;
    cmd.op    = DP_NOP;
    cmd.sel   = sel_r;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // No word is taken while reset is held.
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.op    = DP_CAPTURE;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status.is_start) begin
          cmd.op    = DP_START;
          state_nxt = ST_DONE;
        end else begin
          cmd.op = DP_SCALE_CHK;
          // A finished scale phase holds the size, so no ramp is computed.
          if (status.scale_due) begin
            state_nxt = ST_MOVE;
          end else begin
            sel_nxt   = RAMP_W;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.op    = DP_MUL;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.op  = DP_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        cmd.op = DP_WRITE;
        unique case (sel_r)
          RAMP_W: begin
            sel_nxt   = RAMP_H;
            state_nxt = ST_MUL;
          end
          RAMP_H: state_nxt = ST_MOVE;
          RAMP_A: state_nxt = ST_DONE;
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_MOVE: begin
        cmd.op    = DP_MOVE;
        state_nxt = ST_FADE;
      end
      ST_FADE: begin
        cmd.op = DP_FADE_CHK;
        if (status.fade_due) begin
          state_nxt = ST_DONE;
        end else begin
          sel_nxt   = RAMP_A;
          state_nxt = ST_MUL;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.op    = DP_PUBLISH;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- design/sbsfa_dp.sv -----
// ----------------------------------------------------------------------------
// sbsfa_dp
// Datapath: configuration, sprite state, ramp multiplier, shared divider,
// bounce logic and the output register.
// ----------------------------------------------------------------------------
module sbsfa_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sbsfa_pkg::dp_cmd_t            cmd,
  output sbsfa_pkg::dp_status_t         status,
  input  logic                          in_tuser,
  input  logic [sbsfa_pkg::DATA_W-1:0]  in_tdata,
  input  logic                          cfg_valid,
  input  logic [sbsfa_pkg::IDX_W-1:0]   cfg_index,
  input  logic [sbsfa_pkg::PER_W-1:0]   cfg_data,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [sbsfa_pkg::DATA_W-1:0]  out_tdata
);
  import sbsfa_pkg::*;

  // Configuration registers.
  logic [COORD_W-1:0] win_w_r, win_h_r, min_w_r, min_h_r, max_w_r, max_h_r;
  logic [PER_W-1:0]   fade_per_r, scale_per_r;

  // Captured input word.
  logic               cmd_r;
  logic [TIME_W-1:0]  now_r;
  logic [COORD_W-1:0] sx_r, sy_r;
  logic [STEP_W-1:0]  sdx_r, sdy_r;

  // Sprite state.
  logic [COORD_W-1:0] cur_x_r, cur_y_r, cur_w_r, cur_h_r;
  logic [STEP_W-1:0]  step_x_r, step_y_r;
  logic [ALPHA_W-1:0] cur_alpha_r;
  logic [TIME_W-1:0]  scale_start_r, fade_start_r;
  logic               growing_r, fading_in_r;

  // Divider: remainder and quotient shift register.
  logic [PER_W-1:0]   rem_r;
  logic [QUO_W-1:0]   quo_r;

  logic               out_valid_r;
  logic [DATA_W-1:0]  out_data_r;

  logic [TIME_W-1:0]  el_s, el_f;
  logic [COORD_W-1:0] mw_eff, mh_eff, span;
  logic [PER_W-1:0]   ramp_t, divisor;
  logic [PROD_W-1:0]  prod;
  logic [PER_W:0]     shifted, diff;
  logic               ge;
  logic [COORD_W-1:0] x_nxt, y_nxt;
  logic [STEP_W-1:0]  dx_nxt, dy_nxt;

  function automatic logic [COORD_W+STEP_W-1:0] move_axis(
    input logic [COORD_W-1:0] pos,
    input logic [STEP_W-1:0]  step,
    input logic [COORD_W-1:0] size,
    input logic [COORD_W-1:0] limit
  );
    logic signed [COORD_W+2:0] np;
    logic signed [COORD_W+2:0] np_far;
    logic [STEP_W-1:0]         neg;
    np     = $signed({3'b000, pos}) + $signed({{(COORD_W+3-STEP_W){step[STEP_W-1]}}, step});
    np_far = np + $signed({3'b000, size});
    // Negating the most negative step saturates to the most positive one.
    neg = (step == {1'b1, {(STEP_W-1){1'b0}}}) ? {1'b0, {(STEP_W-1){1'b1}}} : (~step + 1'b1);
    if (!np[COORD_W+2] && (np_far < $signed({3'b000, limit}))) begin
      move_axis = {np[COORD_W-1:0], step};
    end else begin
      move_axis = {pos, neg};
    end
  endfunction

  assign el_s   = now_r - scale_start_r;
  assign el_f   = now_r - fade_start_r;
  assign mw_eff = (max_w_r < min_w_r) ? min_w_r : max_w_r;
  assign mh_eff = (max_h_r < min_h_r) ? min_h_r : max_h_r;

  assign status.is_start  = (cmd_r == CMD_START);
  assign status.scale_due = (el_s >= TIME_W'(scale_per_r));
  assign status.fade_due  = (el_f >= TIME_W'(fade_per_r));
  assign status.out_free  = !out_valid_r || out_tready;

  // Ramp operands. Inside a phase the elapsed time is below the period,
  // so its low bits are the whole value.
  always_comb begin
    unique case (cmd.sel)
      RAMP_W: begin
        span    = mw_eff - min_w_r;
        divisor = scale_per_r;
        ramp_t  = growing_r ? el_s[PER_W-1:0] : (scale_per_r - el_s[PER_W-1:0]);
      end
      RAMP_H: begin
        span    = mh_eff - min_h_r;
        divisor = scale_per_r;
        ramp_t  = growing_r ? el_s[PER_W-1:0] : (scale_per_r - el_s[PER_W-1:0]);
      end
      RAMP_A: begin
        span    = COORD_W'(FULL_ALPHA);
        divisor = fade_per_r;
        ramp_t  = fading_in_r ? el_f[PER_W-1:0] : (fade_per_r - el_f[PER_W-1:0]);
      end
      default: begin
        span    = '0;
        divisor = scale_per_r;
        ramp_t  = '0;
      end
    endcase
  end

  assign prod    = PROD_W'(span) * PROD_W'(ramp_t);
  assign shifted = {rem_r, quo_r[QUO_W-1]};
  assign ge      = (shifted >= {1'b0, divisor});
  assign diff    = shifted - {1'b0, divisor};

  assign {x_nxt, dx_nxt} = move_axis(cur_x_r, step_x_r, cur_w_r, win_w_r);
  assign {y_nxt, dy_nxt} = move_axis(cur_y_r, step_y_r, cur_h_r, win_h_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_w_r     <= WIN_W_RST;
      win_h_r     <= WIN_H_RST;
      min_w_r     <= MIN_RST;
      min_h_r     <= MIN_RST;
      max_w_r     <= MAX_RST;
      max_h_r     <= MAX_RST;
      fade_per_r  <= PER_RST;
      scale_per_r <= PER_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WIN_W:     win_w_r     <= cfg_data[COORD_W-1:0];
        CFG_WIN_H:     win_h_r     <= cfg_data[COORD_W-1:0];
        CFG_MIN_W:     min_w_r     <= cfg_data[COORD_W-1:0];
        CFG_MIN_H:     min_h_r     <= cfg_data[COORD_W-1:0];
        CFG_MAX_W:     max_w_r     <= cfg_data[COORD_W-1:0];
        CFG_MAX_H:     max_h_r     <= cfg_data[COORD_W-1:0];
        CFG_FADE_PER:  fade_per_r  <= cfg_data;
        CFG_SCALE_PER: scale_per_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Payload registers: input capture, divider and output data.
  always_ff @(posedge clk) begin
    if (cmd.op == DP_CAPTURE) begin
      cmd_r <= in_tuser;
      now_r <= in_tdata[31:0];
      sx_r  <= in_tdata[43:32];
      sy_r  <= in_tdata[55:44];
      sdx_r <= in_tdata[63:56];
      sdy_r <= in_tdata[71:64];
    end
    if (cmd.op == DP_MUL) begin
      {rem_r, quo_r} <= prod;
    end else if (cmd.op == DP_DIV_STEP) begin
      rem_r <= ge ? diff[PER_W-1:0] : shifted[PER_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
    if (cmd.op == DP_PUBLISH) begin
      out_data_r <= {step_y_r, step_x_r, cur_alpha_r, cur_h_r, cur_w_r, cur_y_r, cur_x_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      step_x_r      <= '0;
      step_y_r      <= '0;
      cur_w_r       <= MIN_RST;
      cur_h_r       <= MIN_RST;
      cur_alpha_r   <= FULL_ALPHA;
      scale_start_r <= '0;
      fade_start_r  <= '0;
      growing_r     <= 1'b1;
      fading_in_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      unique case (cmd.op)
        DP_START: begin
          cur_x_r       <= sx_r;
          cur_y_r       <= sy_r;
          step_x_r      <= sdx_r;
          step_y_r      <= sdy_r;
          scale_start_r <= now_r;
          fade_start_r  <= now_r;
          growing_r     <= 1'b1;
          fading_in_r   <= 1'b0;
        end
        DP_SCALE_CHK: begin
          if (status.scale_due) begin
            scale_start_r <= now_r;
            growing_r     <= !growing_r;
          end
        end
        DP_WRITE: begin
          unique case (cmd.sel)
            RAMP_W:  cur_w_r     <= min_w_r + quo_r;
            RAMP_H:  cur_h_r     <= min_h_r + quo_r;
            RAMP_A:  cur_alpha_r <= quo_r[ALPHA_W-1:0];
            default: ;
          endcase
        end
        DP_MOVE: begin
          cur_x_r  <= x_nxt;
          cur_y_r  <= y_nxt;
          step_x_r <= dx_nxt;
          step_y_r <= dy_nxt;
        end
        DP_FADE_CHK: begin
          if (status.fade_due) begin
            fade_start_r <= now_r;
            fading_in_r  <= !fading_in_r;
          end
        end
        default: ;
      endcase
      if (cmd.op == DP_PUBLISH) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- design/sprite_bounce_scale_fade_animator.sv -----
// ----------------------------------------------------------------------------
// sprite_bounce_scale_fade_animator
// Animates one sprite: bounce within a window, linear scale and fade ramps.
// ----------------------------------------------------------------------------
// Each input word is a start (tuser high: load position and velocity, restart
// both periods) or a tick (tuser low: update size, then position, then alpha
// for the time now_ms). Every word yields exactly one output word with the
// sprite state after it. Registers are written over the cfg channel, which is
// ready whenever reset is released; they are expected to change only while
// the block is idle.
// Words are handled one at a time. A start goes through decode and then
// publishes its output word, after which the next word can be accepted.
// A tick passes each of the three ramps through the multiplier and then the
// shared restoring divider, which yields its 12-bit quotient one bit per
// cycle, plus a write-back step; a phase that ends skips its ramp.
// The result sits in an output register, so the next input word is taken
// while it waits; if the receiver stalls, the following result waits in the
// sequencer and no further word is accepted until the register frees up.
// Reset (rst_n low, synchronous) restores the default registers, places the
// sprite at the origin at rest, minimum size, full alpha, growing and fading
// out, and empties the output.
// ----------------------------------------------------------------------------
module sprite_bounce_scale_fade_animator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // tdata: now_ms[31:0], start_x[43:32], start_y[55:44], start_dx[63:56],
  //        start_dy[71:64]
  input  logic [sbsfa_pkg::DATA_W-1:0]  in_tdata,
  // tuser: cmd (0 tick, 1 start)
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // tdata: pos_x[11:0], pos_y[23:12], width[35:24], height[47:36],
  //        alpha[55:48], velocity_x[63:56], velocity_y[71:64]
  output logic [sbsfa_pkg::DATA_W-1:0]  out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sbsfa_pkg::IDX_W-1:0]   cfg_index,
  input  logic [sbsfa_pkg::PER_W-1:0]   cfg_data
);
  import sbsfa_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = rst_n;

  sbsfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  sbsfa_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
